### rtl/core/mie_pkg.sv
package mie_pkg;

   localparam int unsigned DEF_WIDTH = 32;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RED  = 4'b0010,
      ST_CHK  = 4'b0100,
      ST_LOOP = 4'b1000
   } state_type;

endpackage

### rtl/core/mie_div.sv
module mie_div #(
   parameter int unsigned WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   input  logic [WIDTH-1:0] mult,
   output logic             done,
   output logic [WIDTH-1:0] remainder,
   output logic [WIDTH-1:0] product
);
   import mie_pkg::*;

   localparam int unsigned CW = $clog2(WIDTH + 1);
   localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [WIDTH-1:0] mul_ff, mul_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   acc_sum;
   logic             ge;

   // one quotient bit per cycle, product accumulated msb first
   always_comb begin
      trial   = {rem_ff, quo_ff[WIDTH-1]};
      ge      = trial >= {1'b0, dsr_ff};
      acc_sum = {acc_ff, 1'b0} + (ge ? {1'b0, mul_ff} : '0);
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      mul_in  = mul_ff;
      acc_in  = acc_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         mul_in = mult;
         acc_in = '0;
      end else if (run_ff) begin
         rem_in = ge ? WIDTH'(trial - {1'b0, dsr_ff}) : trial[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], ge};
         acc_in = acc_sum[WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      mul_ff <= mul_in;
      acc_ff <= acc_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
   assign product   = acc_ff;

endmodule

### rtl/core/modular_inverse_ext_euclid.sv
// Modular inverse by the extended Euclidean algorithm. Pulse start while busy is low with
// req_totient and req_public_exponent; one result follows with rsp_valid high for a single
// cycle, giving rsp_inverse in 0 .. totient-1 and rsp_invertible set when the gcd is one
// (inverse and flag are zero otherwise, and for a zero totient). The receiver cannot stall,
// so capture the result in the strobe cycle. Each quotient comes from one shared
// shift-subtract divider producing one bit per cycle, and an item takes at most
// about 1.44 * WIDTH quotient steps.
module modular_inverse_ext_euclid #(
   parameter int unsigned WIDTH = mie_pkg::DEF_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [WIDTH-1:0] req_totient,
   input  logic [WIDTH-1:0] req_public_exponent,
   output logic             rsp_valid,
   output logic [WIDTH-1:0] rsp_inverse,
   output logic             rsp_invertible
);
   import mie_pkg::*;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] t_ff, t_in;
   logic [WIDTH-1:0] r0_ff, r0_in;
   logic [WIDTH-1:0] r1_ff, r1_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic             nega_ff, nega_in;
   logic             negb_ff, negb_in;
   logic             vld_ff, vld_in;
   logic [WIDTH-1:0] inv_ff, inv_in;
   logic             ok_ff, ok_in;
   logic             div_start;
   logic [WIDTH-1:0] div_dividend, div_divisor, div_mult;
   logic             div_done;
   logic [WIDTH-1:0] div_rem, div_prod;
   logic [WIDTH-1:0] a_red;

   mie_div #(.WIDTH(WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .mult      (div_mult),
      .done      (div_done),
      .remainder (div_rem),
      .product   (div_prod)
   );

   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      nega_in      = nega_ff;
      negb_in      = negb_ff;
      vld_in       = 1'b0;
      inv_in       = inv_ff;
      ok_in        = ok_ff;
      div_start    = 1'b0;
      div_dividend = r0_ff;
      div_divisor  = r1_ff;
      div_mult     = b_ff;
      a_red        = (a_ff == t_ff) ? '0 : a_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               t_in = req_totient;
               if (req_totient == '0) begin
                  vld_in = 1'b1;
                  inv_in = '0;
                  ok_in  = 1'b0;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = req_public_exponent;
                  div_divisor  = req_totient;
                  div_mult     = '0;
                  state_in     = ST_RED;
               end
            end
         end
         ST_RED: begin
            if (div_done) begin
               r0_in    = t_ff;
               r1_in    = div_rem;
               a_in     = '0;
               b_in     = WIDTH'(1);
               nega_in  = 1'b1;
               negb_in  = 1'b0;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (r1_ff == '0) begin
               vld_in   = 1'b1;
               ok_in    = r0_ff == WIDTH'(1);
               inv_in   = '0;
               if (r0_ff == WIDTH'(1)) begin
                  inv_in = (nega_ff && a_red != '0) ? t_ff - a_red : a_red;
               end
               state_in = ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (div_done) begin
               r0_in    = r1_ff;
               r1_in    = div_rem;
               a_in     = b_ff;
               b_in     = div_prod + a_ff;
               nega_in  = negb_ff;
               negb_in  = !negb_ff;
               state_in = ST_CHK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      t_ff    <= t_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      nega_ff <= nega_in;
      negb_ff <= negb_in;
      inv_ff  <= inv_in;
      ok_ff   <= ok_in;
   end

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = vld_ff;
   assign rsp_inverse    = inv_ff;
   assign rsp_invertible = ok_ff;

   a_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_RED || state_ff == ST_LOOP))
      else $error("divider finished outside a division state");

   a_rem_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHK |-> r1_ff < r0_ff)
      else $error("remainder not below previous remainder");

   a_sign_alt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHK |-> negb_ff != nega_ff)
      else $error("coefficient signs do not alternate");

endmodule

### sim/modular_inverse_ext_euclid_tb.sv
module modular_inverse_ext_euclid_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = mie_pkg::DEF_WIDTH;
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct {
      logic [W-1:0] totient;
      logic [W-1:0] exponent;
      bit           drain_first;
   } operand_pair_type;

   typedef struct {
      logic [W-1:0] inverse;
      logic         invertible;
   } inverse_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [W-1:0] req_totient = '0;
   logic [W-1:0] req_public_exponent = '0;
   logic rsp_valid;
   logic [W-1:0] rsp_inverse;
   logic rsp_invertible;

   operand_pair_type   pending_pairs[$];
   inverse_result_type expected_inverses[$];
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  gap_left = 0;

   modular_inverse_ext_euclid #(.WIDTH(W)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_totient(req_totient), .req_public_exponent(req_public_exponent),
      .rsp_valid(rsp_valid), .rsp_inverse(rsp_inverse), .rsp_invertible(rsp_invertible)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic inverse_result_type mod_inverse(logic [W-1:0] t_in, logic [W-1:0] e_in);
      longint unsigned t, r0, r1, a, b, q, rn, sn;
      bit neg_a, neg_b, nb;
      inverse_result_type res;
      t = t_in;
      res.inverse = '0;
      res.invertible = 1'b0;
      if (t != 0) begin
         r0 = t;
         r1 = longint'(e_in) % t;
         a = 0;
         b = 1;
         neg_a = 0;
         neg_b = 0;
         while (r1 != 0) begin
            q = r0 / r1;
            rn = r0 - q * r1;
            sn = a + q * b;
            nb = !neg_b;
            r0 = r1;
            r1 = rn;
            a = b;
            neg_a = neg_b;
            b = sn;
            neg_b = nb;
         end
         if (r0 == 1) begin
            res.invertible = 1'b1;
            a = a % t;
            res.inverse = (neg_a && a != 0) ? W'(t - a) : W'(a);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic add_pair(logic [W-1:0] t, logic [W-1:0] e, bit drain = 0);
      operand_pair_type p;
      p.totient = t;
      p.exponent = e;
      p.drain_first = drain;
      pending_pairs.insert(pending_pairs.size(), p);
   endtask

   // driver
   always @(posedge clock) begin
      operand_pair_type p;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !busy) begin
         expected_inverses.insert(expected_inverses.size(),
            mod_inverse(req_totient, req_public_exponent));
         if (pending_pairs.size() != 0 && !pending_pairs[0].drain_first
               && $urandom_range(0, 3) == 0) begin
            p = pending_pairs.pop_front();
            req_totient <= p.totient;
            req_public_exponent <= p.exponent;
         end else begin
            start <= 1'b0;
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_pairs.size() != 0 &&
               (!pending_pairs[0].drain_first || expected_inverses.size() == 0)) begin
            p = pending_pairs.pop_front();
            req_totient <= p.totient;
            req_public_exponent <= p.exponent;
            start <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      inverse_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_inverses.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_inverse, '0);
         end else begin
            want = expected_inverses.pop_front();
            if (rsp_inverse !== want.inverse)
               report_mismatch("inverse", rsp_inverse, want.inverse);
            if (rsp_invertible !== want.invertible)
               report_mismatch("invertible", W'(rsp_invertible), W'(want.invertible));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [W-1:0] t, e, f;
      int kind;
      // directed
      add_pair(0, 0);
      add_pair(0, 7);
      add_pair(1, 0);
      add_pair(1, 12345);
      add_pair(2, 0);
      add_pair(2, 1);
      add_pair(2, 3);
      add_pair(7, 7);
      add_pair(7, 15);
      add_pair(12, 8);
      add_pair(3120, 17);
      add_pair(40, 3);
      add_pair('1, '1);
      add_pair('1, {W{1'b1}} - 1);
      add_pair('1, 1);
      add_pair(32'd2971215073, 32'd1836311903);
      add_pair(32'd1836311903, 32'd2971215073);
      add_pair(32'h8000_0000, 32'h7fff_ffff);
      add_pair(32'h8000_0000, 32'h5555_5555);
      add_pair(32'h5555_5555, 32'haaaa_aaaa);
      add_pair(32'hffff_fffe, 32'h0000_0003);
      // random
      for (int i = 0; i < 1600; i++) begin
         kind = $urandom_range(0, 9);
         t = $urandom();
         e = $urandom();
         case (kind)
            0: begin
               t = $urandom_range(2, 1000);
               e = $urandom_range(0, 2000);
            end
            1: begin
               f = $urandom_range(2, 60);
               t = f * $urandom_range(1, 32'h0400_0000);
               e = f * $urandom_range(0, 32'h0400_0000);
            end
            2: e = $urandom_range(0, 3);
            3: t = $urandom_range(0, 3);
            4: e = (t == 0) ? e : e % t;
            default: ;
         endcase
         add_pair(t, e, (i == 0) || (i == 800) || ($urandom_range(0, 199) == 0));
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_pairs.size() != 0 || start) @(posedge clock);
      while (expected_inverses.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_inverses.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
